// File: design/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, widths, register indexes and reset values of the particle
// step unit.
// ----------------------------------------------------------------------------
package gps_pkg;

  // Coordinates, velocities and source positions are signed Q16.16.
  localparam int unsigned COORD_W = 32;
  // Source strength is unsigned Q16.8.
  localparam int unsigned STR_W   = 24;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned IDX_W   = 3;

  // Largest number of sources the register map provides for.
  localparam int unsigned MAX_SOURCES_LIMIT = 2;
  localparam int unsigned MAX_SOURCES_DEF   = 2;

  // Register map. Each source owns three consecutive indexes.
  localparam int unsigned REG_SRC0_X       = 0;
  localparam int unsigned REG_SRC0_Y       = 1;
  localparam int unsigned REG_SRC0_STR     = 2;
  localparam int unsigned REGS_PER_SRC     = 3;
  localparam int unsigned REG_SOURCE_COUNT = 6;

  localparam logic [COORD_W-1:0] SRC_X_RST [MAX_SOURCES_LIMIT] = '{32'd32768000, 32'd78643200};
  localparam logic [COORD_W-1:0] SRC_Y_RST [MAX_SOURCES_LIMIT] = '{32'd32768000, 32'd32768000};
  localparam logic [STR_W-1:0]   SRC_STR_RST [MAX_SOURCES_LIMIT] = '{24'd1792000, 24'd1792000};
  localparam logic [CNT_W-1:0]   COUNT_RST = 2'd2;

  // Distance: floor(sqrt(dx^2 + dy^2)), radicand padded to an even width.
  localparam int unsigned SQ_RAD_W  = 66;
  localparam int unsigned SQ_ROOT_W = 33;

  // Gravity magnitude: floor(strength * 2^40 / dist^2).
  localparam int unsigned G_SHIFT   = 40;
  localparam int unsigned GDIV_N_W  = 65;
  localparam int unsigned GDIV_D_W  = 66;
  localparam int unsigned GDIV_Q_W  = 64;

  // Direction cosine: floor(|d| * 2^30 / dist), at most 2^30.
  localparam int unsigned NFRAC     = 30;
  localparam int unsigned NDIV_N_W  = COORD_W + NFRAC;
  localparam int unsigned NDIV_D_W  = SQ_ROOT_W;
  localparam int unsigned NDIV_Q_W  = NFRAC + 1;

  // Acceleration magnitude, held at 2^33.
  localparam int unsigned ACC_W     = 34;

  // Register stages of one source section.
  localparam int unsigned SRC_LATENCY = 4 + SQ_ROOT_W + 1 + GDIV_Q_W + 4;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic               sat;
    logic               onsrc;
  } item_t;

  typedef struct packed {
    item_t              item;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic               sgn_x;
    logic               sgn_y;
    logic               zero;
  } side_t;

endpackage

// File: design/gps_delay.sv
// ----------------------------------------------------------------------------
// gps_delay
// Enabled register line that keeps side data aligned with a long datapath.
// ----------------------------------------------------------------------------
module gps_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

// File: design/gps_isqrt.sv
// ----------------------------------------------------------------------------
// gps_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module gps_isqrt #(
  parameter int unsigned RAD_W  = 66,
  parameter int unsigned ROOT_W = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  sub;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    // Bring down two radicand bits and try 4*root + 1.
    assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign sub   = (REM_W+2)'({root_in, 2'b01});
    assign ge    = trial >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? REM_W'(trial - sub) : REM_W'(trial);
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (k < ROOT_W - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k] <= rad_in << 2;
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// File: design/gps_divider.sv
// ----------------------------------------------------------------------------
// gps_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module gps_divider #(
  parameter int unsigned NUM_W = 65,
  parameter int unsigned DEN_W = 66,
  parameter int unsigned QUO_W = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // The numerator bits above the quotient width must be below the divisor.
  logic [DEN_W-1:0] rem_r [QUO_W-1];
  logic [QUO_W-1:0] low_r [QUO_W-1];
  logic [DEN_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   part;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
      assign low_in = num[QUO_W-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign part = {rem_in, low_in[QUO_W-1]};
    assign diff = part - {1'b0, den_in};
    assign ge   = part >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
          low_r[k] <= low_in << 1;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// File: design/gps_source.sv
// ----------------------------------------------------------------------------
// gps_source
// Pipeline section that applies one gravity source to a particle word.
// ----------------------------------------------------------------------------
module gps_source import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               active,
  input  logic [COORD_W-1:0] src_x,
  input  logic [COORD_W-1:0] src_y,
  input  logic [STR_W-1:0]   strength,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               out_valid,
  output item_t              out_item
);

  localparam int unsigned SUM_W  = ACC_W + 2;
  localparam int unsigned PROD_W = COORD_W + NDIV_Q_W;
  localparam int unsigned HALF_G = GDIV_Q_W / 2;
  localparam int unsigned NDLY   = GDIV_Q_W - NDIV_Q_W;
  localparam logic [PROD_W+2:0] ACC_HOLD = (PROD_W+3)'(1) << (ACC_W - 1);

  // Returns {clamped, value}: saturation to signed 32 bits.
  function automatic logic [COORD_W:0] sat_clamp(input logic [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] hi;
    hi = v[SUM_W-1:COORD_W-1];
    if (hi == '0 || hi == '1) begin
      return {1'b0, v[COORD_W-1:0]};
    end else if (v[SUM_W-1]) begin
      return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // floor(g * n / 2^30) from the split products, held at 2^33.
  function automatic logic [ACC_W-1:0] cap_acc(input logic [PROD_W-1:0] phi,
                                               input logic [PROD_W-1:0] plo);
    logic [PROD_W+2:0] s;
    s = {1'b0, phi, 2'b00} + (PROD_W+3)'(plo >> NFRAC);
    return (s > ACC_HOLD) ? ACC_HOLD[ACC_W-1:0] : s[ACC_W-1:0];
  endfunction

  // Valid bits of every stage.
  logic                v0, v1, v2, v3, v4, v5, v6, v7, v8;
  logic [SQ_ROOT_W-1:0] vsq;
  logic [GDIV_Q_W-1:0]  vdv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vsq <= '0;
      v4  <= 1'b0;
      vdv <= '0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
    end else if (en) begin
      v0  <= in_valid;
      v1  <= v0;
      v2  <= v1;
      v3  <= v2;
      vsq <= {vsq[SQ_ROOT_W-2:0], v3};
      v4  <= vsq[SQ_ROOT_W-1];
      vdv <= {vdv[GDIV_Q_W-2:0], v4};
      v5  <= vdv[GDIV_Q_W-1];
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
    end
  end

  // Stage 0: offset from the particle to the source.
  item_t            item0;
  logic [COORD_W:0] dx0, dy0;

  always_ff @(posedge clk) begin
    if (en) begin
      item0 <= in_item;
      dx0   <= {src_x[COORD_W-1], src_x} - {in_item.px[COORD_W-1], in_item.px};
      dy0   <= {src_y[COORD_W-1], src_y} - {in_item.py[COORD_W-1], in_item.py};
    end
  end

  // Stage 1: magnitudes and signs.
  logic [COORD_W:0] ax_c, ay_c;
  side_t            side1, side2, side3, side_sq, side4, side_dv;
  side_t            side5, side6;

  assign ax_c = dx0[COORD_W] ? (~dx0 + 1'b1) : dx0;
  assign ay_c = dy0[COORD_W] ? (~dy0 + 1'b1) : dy0;

  always_ff @(posedge clk) begin
    if (en) begin
      side1.item  <= item0;
      side1.ax    <= ax_c[COORD_W-1:0];
      side1.ay    <= ay_c[COORD_W-1:0];
      side1.sgn_x <= dx0[COORD_W];
      side1.sgn_y <= dy0[COORD_W];
      side1.zero  <= (dx0 == '0) && (dy0 == '0);
    end
  end

  // Stage 2: squares. Stage 3: their sum.
  logic [2*COORD_W-1:0] sqx2, sqy2;
  logic [2*COORD_W:0]   sum3;

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side1;
      sqx2  <= (2*COORD_W)'(side1.ax) * (2*COORD_W)'(side1.ax);
      sqy2  <= (2*COORD_W)'(side1.ay) * (2*COORD_W)'(side1.ay);
      side3 <= side2;
      sum3  <= (2*COORD_W+1)'(sqx2) + (2*COORD_W+1)'(sqy2);
    end
  end

  // Distance.
  logic [SQ_ROOT_W-1:0] dist_sq;

  gps_isqrt #(
    .RAD_W  (SQ_RAD_W),
    .ROOT_W (SQ_ROOT_W)
  ) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (SQ_RAD_W'(sum3)),
    .root (dist_sq)
  );

  gps_delay #(
    .W     ($bits(side_t)),
    .DEPTH (SQ_ROOT_W)
  ) u_side_sq (
    .clk (clk),
    .en  (en),
    .d   (side3),
    .q   (side_sq)
  );

  // Stage 4: distance and its square.
  logic [GDIV_D_W-1:0]  dist_ext;
  logic [SQ_ROOT_W-1:0] dist4;
  logic [GDIV_D_W-1:0]  dist2_4;

  assign dist_ext = GDIV_D_W'(dist_sq);

  always_ff @(posedge clk) begin
    if (en) begin
      side4   <= side_sq;
      dist4   <= dist_sq;
      dist2_4 <= dist_ext * dist_ext;
    end
  end

  // Gravity magnitude and the two direction cosines.
  logic [GDIV_N_W-1:0]   g_num;
  logic [GDIV_Q_W-1:0]   g_quo;
  logic [NDIV_Q_W-1:0]   nx_quo, ny_quo;
  logic [2*NDIV_Q_W-1:0] n_dly;
  logic [NDIV_Q_W-1:0]   nx_d, ny_d;

  assign g_num = GDIV_N_W'(strength) << G_SHIFT;

  gps_divider #(
    .NUM_W (GDIV_N_W),
    .DEN_W (GDIV_D_W),
    .QUO_W (GDIV_Q_W)
  ) u_gdiv (
    .clk (clk),
    .en  (en),
    .num (g_num),
    .den (dist2_4),
    .quo (g_quo)
  );

  gps_divider #(
    .NUM_W (NDIV_N_W),
    .DEN_W (NDIV_D_W),
    .QUO_W (NDIV_Q_W)
  ) u_nxdiv (
    .clk (clk),
    .en  (en),
    .num ({side4.ax, {NFRAC{1'b0}}}),
    .den (dist4),
    .quo (nx_quo)
  );

  gps_divider #(
    .NUM_W (NDIV_N_W),
    .DEN_W (NDIV_D_W),
    .QUO_W (NDIV_Q_W)
  ) u_nydiv (
    .clk (clk),
    .en  (en),
    .num ({side4.ay, {NFRAC{1'b0}}}),
    .den (dist4),
    .quo (ny_quo)
  );

  gps_delay #(
    .W     (2*NDIV_Q_W),
    .DEPTH (NDLY)
  ) u_n_dly (
    .clk (clk),
    .en  (en),
    .d   ({ny_quo, nx_quo}),
    .q   (n_dly)
  );

  assign {ny_d, nx_d} = n_dly;

  gps_delay #(
    .W     ($bits(side_t)),
    .DEPTH (GDIV_Q_W)
  ) u_side_dv (
    .clk (clk),
    .en  (en),
    .d   (side4),
    .q   (side_dv)
  );

  // Stage 5: partial products of g * n. Stage 6: acceleration magnitude.
  logic [PROD_W-1:0] plo_x5, phi_x5, plo_y5, phi_y5;
  logic [ACC_W-1:0]  amx6, amy6;

  always_ff @(posedge clk) begin
    if (en) begin
      side5  <= side_dv;
      plo_x5 <= PROD_W'(g_quo[HALF_G-1:0]) * PROD_W'(nx_d);
      phi_x5 <= PROD_W'(g_quo[GDIV_Q_W-1:HALF_G]) * PROD_W'(nx_d);
      plo_y5 <= PROD_W'(g_quo[HALF_G-1:0]) * PROD_W'(ny_d);
      phi_y5 <= PROD_W'(g_quo[GDIV_Q_W-1:HALF_G]) * PROD_W'(ny_d);
      side6  <= side5;
      amx6   <= cap_acc(phi_x5, plo_x5);
      amy6   <= cap_acc(phi_y5, plo_y5);
    end
  end

  // Stage 7: velocity update.
  logic [SUM_W-1:0] accx, accy, vsum_x, vsum_y;
  logic [COORD_W:0] vcl_x, vcl_y;
  item_t            item7_c, item7;

  assign accx   = side6.sgn_x ? (~SUM_W'(amx6) + 1'b1) : SUM_W'(amx6);
  assign accy   = side6.sgn_y ? (~SUM_W'(amy6) + 1'b1) : SUM_W'(amy6);
  assign vsum_x = SUM_W'($signed(side6.item.vx)) + accx;
  assign vsum_y = SUM_W'($signed(side6.item.vy)) + accy;
  assign vcl_x  = sat_clamp(vsum_x);
  assign vcl_y  = sat_clamp(vsum_y);

  always_comb begin
    item7_c = side6.item;
    if (active) begin
      if (side6.zero) begin
        item7_c.onsrc = 1'b1;
      end else begin
        item7_c.vx  = vcl_x[COORD_W-1:0];
        item7_c.vy  = vcl_y[COORD_W-1:0];
        item7_c.sat = side6.item.sat | vcl_x[COORD_W] | vcl_y[COORD_W];
      end
    end
  end

  // Stage 8: position update.
  logic [SUM_W-1:0] psum_x, psum_y;
  logic [COORD_W:0] pcl_x, pcl_y;
  item_t            item8_c, item8;

  assign psum_x = SUM_W'($signed(item7.px)) + SUM_W'($signed(item7.vx));
  assign psum_y = SUM_W'($signed(item7.py)) + SUM_W'($signed(item7.vy));
  assign pcl_x  = sat_clamp(psum_x);
  assign pcl_y  = sat_clamp(psum_y);

  always_comb begin
    item8_c = item7;
    if (active) begin
      item8_c.px  = pcl_x[COORD_W-1:0];
      item8_c.py  = pcl_y[COORD_W-1:0];
      item8_c.sat = item7.sat | pcl_x[COORD_W] | pcl_y[COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item7 <= item7_c;
      item8 <= item8_c;
    end
  end

  assign out_valid = v8;
  assign out_item  = item8;

endmodule

// File: design/gravity_particle_step_unit.sv
// ----------------------------------------------------------------------------
// gravity_particle_step_unit
// One Euler step of a particle under up to two inverse-square point sources.
// ----------------------------------------------------------------------------
// The unit takes one particle word per clock and returns one updated word per
// clock, in order, unless the output stalls. Each enabled source (source 0
// first, then source 1) adds strength * d / |d|^3 to the velocity and then
// adds the velocity to the position, all in signed Q16.16 with truncation
// toward zero and saturation to 32 bits. Each source is a fully pipelined
// section of SRC_LATENCY (106) register stages, dominated by the 64-stage
// bit-per-cycle divider that forms strength / distance^2 and the 33-stage
// square-root pipeline; a word passes through MAX_SOURCES such sections and
// then the output register. Sources that the source count leaves off still
// take their stages but pass the word through unchanged. When the output is
// stalled, the pipeline keeps filling until a finished word reaches its last
// stage; only then does s_tready drop. Configuration writes are taken at any
// time on the cfg channel but must only be issued while the unit is empty.
// ----------------------------------------------------------------------------
module gravity_particle_step_unit import gps_pkg::*; #(
  parameter int unsigned MAX_SOURCES = MAX_SOURCES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input words.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [4*COORD_W-1:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y (low bits first)
  // Result words.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [4*COORD_W-1:0] m_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [1:0]           m_tuser,   // saturated, on_source
  // Register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  // Configuration registers. Writes are always taken; unknown indexes and
  // indexes of sources beyond MAX_SOURCES are dropped.
  logic [COORD_W-1:0] src_x   [MAX_SOURCES];
  logic [COORD_W-1:0] src_y   [MAX_SOURCES];
  logic [STR_W-1:0]   src_str [MAX_SOURCES];
  logic [CNT_W-1:0]   source_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_SOURCES; k++) begin
        src_x[k]   <= SRC_X_RST[k];
        src_y[k]   <= SRC_Y_RST[k];
        src_str[k] <= SRC_STR_RST[k];
      end
      source_count <= COUNT_RST;
    end else if (cfg_valid) begin
      for (int k = 0; k < MAX_SOURCES; k++) begin
        if (cfg_index == IDX_W'(REG_SRC0_X + REGS_PER_SRC * k)) begin
          src_x[k] <= cfg_data;
        end
        if (cfg_index == IDX_W'(REG_SRC0_Y + REGS_PER_SRC * k)) begin
          src_y[k] <= cfg_data;
        end
        if (cfg_index == IDX_W'(REG_SRC0_STR + REGS_PER_SRC * k)) begin
          src_str[k] <= cfg_data[STR_W-1:0];
        end
      end
      if (cfg_index == IDX_W'(REG_SOURCE_COUNT)) begin
        source_count <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // A count above the number of built sources applies all of them.
  logic [CNT_W-1:0] count_eff;

  assign count_eff = (source_count > CNT_W'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
                                                          : source_count;

  // Pipeline advance. The whole pipeline moves together; it only holds when
  // its last stage has a word and the output register cannot take it.
  logic                   en;
  logic [MAX_SOURCES:0]   chain_valid;
  item_t                  chain_item [MAX_SOURCES+1];
  logic                   last_valid;
  item_t                  out_item;

  assign last_valid = chain_valid[MAX_SOURCES];
  assign en         = !last_valid || !m_tvalid || m_tready;
  assign s_tready   = en;

  assign chain_valid[0]      = s_tvalid;
  assign chain_item[0].px    = s_tdata[COORD_W-1:0];
  assign chain_item[0].py    = s_tdata[2*COORD_W-1:COORD_W];
  assign chain_item[0].vx    = s_tdata[3*COORD_W-1:2*COORD_W];
  assign chain_item[0].vy    = s_tdata[4*COORD_W-1:3*COORD_W];
  assign chain_item[0].sat   = 1'b0;
  assign chain_item[0].onsrc = 1'b0;

  // One pipeline section per source; each sees the word the previous left.
  for (genvar k = 0; k < MAX_SOURCES; k++) begin : g_src
    gps_source u_source (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .active    (count_eff > CNT_W'(k)),
      .src_x     (src_x[k]),
      .src_y     (src_y[k]),
      .strength  (src_str[k]),
      .in_valid  (chain_valid[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_valid[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_item <= chain_item[MAX_SOURCES];
    end
  end

  assign m_tdata = {out_item.vy, out_item.vx, out_item.py, out_item.px};
  assign m_tuser = {out_item.onsrc, out_item.sat};

  // The input side is only held back by a full output path.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

  // A finished word waiting behind a stalled output must freeze the pipe.
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && last_valid) |-> !s_tready)
    else $error("pipeline advanced over a blocked result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count_eff <= CNT_W'(MAX_SOURCES))
    else $error("effective source count above the built sources");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gravity particle step unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked particles runs first. Then several register
// settings follow, each with a burst of random particles. Both stream sides
// idle at random, except in the last setting. Every word the unit returns is
// compared with a local fixed-point model of the inverse-square Euler step,
// or with a result typed into the table where it is obvious.
// ----------------------------------------------------------------------------
module testbench import gps_pkg::*; ();

  localparam int unsigned REG_SRC1_X   = REG_SRC0_X + REGS_PER_SRC;
  localparam int unsigned REG_SRC1_Y   = REG_SRC0_Y + REGS_PER_SRC;
  localparam int unsigned REG_SRC1_STR = REG_SRC0_STR + REGS_PER_SRC;
  localparam int unsigned REG_UNUSED   = 7;
  localparam int unsigned FLUSH_CYCLES = 2 * SRC_LATENCY + 40;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_WORDS  = 195;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        sat;
    logic        onsrc;
  } particle_t;

  typedef struct {
    logic [1:0] count;
    particle_t  stim;
    bit         typed;
    particle_t  result;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [4*COORD_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [4*COORD_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  // Local copy of the register file.
  logic [31:0] src_x [2];
  logic [31:0] src_y [2];
  logic [23:0] src_str [2];
  logic [1:0]  src_count;

  particle_t expected_q[$];
  // Per sent word: 1 if the table supplies the result, with that result.
  bit        typed_q[$];
  particle_t typed_val_q[$];

  int  mismatches = 0;
  bit  calm = 1'b0;
  int  tx_stall = 0;

  always #4 clk = ~clk;

  gravity_particle_step_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Floor of the square root of a wide unsigned value, bit by bit.
  function automatic logic [127:0] root_floor(logic [127:0] v);
    logic [127:0] res;
    logic [127:0] b;
    res = '0;
    for (int k = 126; k >= 0; k -= 2) begin
      b = 128'd1 << k;
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic longint clamp_q16(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Signed acceleration along one axis: g * |d| / span, truncated, held at 2^33.
  function automatic longint axis_pull(longint d, logic [127:0] span, logic [127:0] g);
    logic [127:0] ad, n, am;
    ad = (d < 0) ? 128'(-d) : 128'(d);
    n  = (ad << 30) / span;
    am = (g * n) >> 30;
    if (am > (128'd1 << 33)) am = 128'd1 << 33;
    return (d < 0) ? -longint'(am) : longint'(am);
  endfunction

  // Apply one source: kick the velocity, then drift the position.
  function automatic void apply_pull(logic [31:0] qx, logic [31:0] qy, logic [23:0] st,
                                     ref longint px, ref longint py,
                                     ref longint vx, ref longint vy,
                                     ref bit sat, ref bit onsrc);
    longint dx, dy;
    logic [127:0] ax, ay, span, g;
    dx = longint'($signed(qx)) - px;
    dy = longint'($signed(qy)) - py;
    if (dx == 0 && dy == 0) begin
      onsrc = 1'b1;
    end else begin
      ax = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay = (dy < 0) ? 128'(-dy) : 128'(dy);
      span = root_floor(ax * ax + ay * ay);
      g = (128'(st) << 40) / (span * span);
      vx = clamp_q16(vx + axis_pull(dx, span, g), sat);
      vy = clamp_q16(vy + axis_pull(dy, span, g), sat);
    end
    px = clamp_q16(px + vx, sat);
    py = clamp_q16(py + vy, sat);
  endfunction

  function automatic particle_t euler_step(particle_t p);
    longint px, py, vx, vy;
    bit sat, onsrc;
    int used;
    particle_t r;
    px = longint'($signed(p.px));
    py = longint'($signed(p.py));
    vx = longint'($signed(p.vx));
    vy = longint'($signed(p.vy));
    sat = 1'b0;
    onsrc = 1'b0;
    used = (src_count > MAX_SOURCES_DEF) ? MAX_SOURCES_DEF : src_count;
    for (int s = 0; s < used; s++)
      apply_pull(src_x[s], src_y[s], src_str[s], px, py, vx, vy, sat, onsrc);
    r.px = px[31:0];
    r.py = py[31:0];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.sat = sat;
    r.onsrc = onsrc;
    return r;
  endfunction

  // Unpack a bus word, first field in the lowest bits, plus the two flags.
  function automatic particle_t from_words(logic [127:0] d, logic [1:0] u);
    particle_t r;
    r.px = d[31:0];
    r.py = d[63:32];
    r.vx = d[95:64];
    r.vy = d[127:96];
    r.sat = u[0];
    r.onsrc = u[1];
    return r;
  endfunction

  // Scoreboard: record what each accepted particle should become, and check
  // every returned word against the oldest entry.
  always @(posedge clk) begin
    particle_t got, want, canned;
    bit is_typed;
    if (!rst && s_tvalid && s_tready) begin
      is_typed = typed_q.pop_front();
      canned = typed_val_q.pop_front();
      if (is_typed)
        expected_q.insert(expected_q.size(), canned);
      else
        expected_q.insert(expected_q.size(), euler_step(from_words(s_tdata, 2'b00)));
    end
    if (!rst && m_tvalid && m_tready) begin
      got = from_words(m_tdata, m_tuser);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected pos %h %h vel %h %h sat %b onsrc %b",
                     want.px, want.py, want.vx, want.vy, want.sat, want.onsrc);
            $display("          got      pos %h %h vel %h %h sat %b onsrc %b",
                     got.px, got.py, got.vx, got.vy, got.sat, got.onsrc);
          end
        end
      end
    end
  end

  // Result side backpressure: bursts of stall, sometimes long quiet runs.
  always @(posedge clk) begin
    if (calm || rst) begin
      m_tready <= 1'b1;
    end else if (tx_stall > 0) begin
      tx_stall <= tx_stall - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      tx_stall <= $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(int unsigned idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx[IDX_W-1:0];
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SRC0_X:       src_x[0]   = val;
      REG_SRC0_Y:       src_y[0]   = val;
      REG_SRC0_STR:     src_str[0] = val[23:0];
      REG_SRC1_X:       src_x[1]   = val;
      REG_SRC1_Y:       src_y[1]   = val;
      REG_SRC1_STR:     src_str[1] = val[23:0];
      REG_SOURCE_COUNT: src_count  = val[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(particle_t p, bit typed, particle_t result);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    typed_q.insert(typed_q.size(), typed);
    typed_val_q.insert(typed_val_q.size(), result);
    s_tvalid <= 1'b1;
    s_tdata  <= {p.vy, p.vx, p.py, p.px};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] spread(int lo, int hi);
    logic [63:0] v;
    int sh;
    sh = $urandom_range(lo, hi);
    v = {$urandom, $urandom} >> (64 - sh);
    return $urandom_range(0, 1) ? v[31:0] : -v[31:0];
  endfunction

  // Random particle: mostly near a source so the pull is strong, with some
  // exact hits, pure noise and extreme values.
  function automatic particle_t random_particle();
    particle_t p;
    int s, kind;
    logic [31:0] edges [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    s = $urandom_range(0, 1);
    kind = $urandom_range(0, 9);
    p = '0;
    if (kind <= 6) begin
      p.px = src_x[s] + ((kind == 6) ? 32'd0 : spread(1, 30));
      p.py = src_y[s] + ((kind == 6) ? 32'd0 : spread(1, 30));
      p.vx = spread(1, 22);
      p.vy = spread(1, 22);
    end else if (kind == 7) begin
      p.px = $urandom; p.py = $urandom; p.vx = $urandom; p.vy = $urandom;
    end else if (kind == 8) begin
      p.px = edges[$urandom_range(0, 3)]; p.py = edges[$urandom_range(0, 3)];
      p.vx = edges[$urandom_range(0, 3)]; p.vy = edges[$urandom_range(0, 3)];
    end else begin
      p.px = src_x[s] + spread(1, 8);
      p.py = src_y[s] + spread(1, 8);
      p.vx = $urandom; p.vy = $urandom;
    end
    return p;
  endfunction

  row_t rows [] = '{
    '{2'd2, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'd32768000, 32'd32768000, 32'h00010000, 32'hffff0000, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'd78643200, 32'd32768000, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'd32768001, 32'd32768000, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'd32768000, 32'd32767999, 32'h7fffffff, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd2, '{32'd45000000, 32'd20000000, 32'h00020000, 32'h00008000, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd3, '{32'd45000000, 32'd20000000, 32'h00020000, 32'h00008000, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd3, '{32'd32768000, 32'd32768000, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    // One source, particle at rest exactly on it: nothing moves, flag set.
    '{2'd1, '{32'd32768000, 32'd32768000, 32'h0, 32'h0, 1'b0, 1'b0},
      1'b1, '{32'd32768000, 32'd32768000, 32'h0, 32'h0, 1'b0, 1'b1}},
    '{2'd1, '{32'd32768000, 32'd32768000, 32'h00010000, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    '{2'd1, '{32'd90000000, 32'hfff00000, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b0, '0},
    // No sources: the particle passes through untouched.
    '{2'd0, '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0},
      1'b1, '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0}},
    '{2'd0, '{32'd32768000, 32'd32768000, 32'h12345678, 32'h9abcdef0, 1'b0, 1'b0},
      1'b1, '{32'd32768000, 32'd32768000, 32'h12345678, 32'h9abcdef0, 1'b0, 1'b0}}
  };

  initial begin
    logic [31:0] coord_edges [2] = '{32'h8000_0000, 32'h7fff_ffff};
    for (int s = 0; s < 2; s++) begin
      src_x[s] = SRC_X_RST[s];
      src_y[s] = SRC_Y_RST[s];
      src_str[s] = SRC_STR_RST[s];
    end
    src_count = COUNT_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked particles; the source count is changed only when idle.
    foreach (rows[r]) begin
      if (rows[r].count != src_count) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        drain();
        write_reg(REG_SOURCE_COUNT, 32'(rows[r].count));
      end
      send_word(rows[r].stim, rows[r].typed, rows[r].result);
    end

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      drain();
      calm = (ph == PHASES - 1);
      for (int s = 0; s < 2; s++) begin
        if (ph == 3) begin
          write_reg(REG_SRC0_X + s * REGS_PER_SRC, coord_edges[s]);
          write_reg(REG_SRC0_Y + s * REGS_PER_SRC, coord_edges[1 - s]);
        end else begin
          write_reg(REG_SRC0_X + s * REGS_PER_SRC, spread(20, 31));
          write_reg(REG_SRC0_Y + s * REGS_PER_SRC, spread(20, 31));
        end
        write_reg(REG_SRC0_STR + s * REGS_PER_SRC,
                  (ph == 1) ? 32'h0 : (ph == 2) ? 32'hffffffff : $urandom);
      end
      write_reg(REG_SOURCE_COUNT, ph % 4);
      // An index outside the map must leave every register alone.
      write_reg(REG_UNUSED, $urandom);
      repeat (PHASE_WORDS) send_word(random_particle(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    drain();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
